/* sv/ssq_pkg.sv */
// Package with the constants, leg codes and helper function of the spiral sequencer.
package ssq_pkg;

    localparam int MAX_RADIUS   = 127;
    localparam int RADIUS_W     = 7;
    localparam int COORD_W      = 8;
    localparam int INDEX_W      = 16;
    localparam int PROGRESS_W   = 8;
    localparam int STEP_W       = 9;
    localparam int RESET_RADIUS = 2;
    localparam int FIRST_STEP   = 2;
    localparam int STEP_GROWTH  = 2;

    typedef enum logic [2:0] {
        LEG_CENTRE = 3'd0,
        LEG_DROP   = 3'd1,
        LEG_RIGHT  = 3'd2,
        LEG_UP     = 3'd3,
        LEG_LEFT   = 3'd4,
        LEG_DOWN   = 3'd5
    } t_leg;

    // Order index of the final cell for a given radius: (2r+1)^2 - 1.
    function automatic logic [INDEX_W-1:0] final_index(input logic [RADIUS_W-1:0] radius);
        logic [RADIUS_W-1:0] r;
        logic [RADIUS_W:0]   side;
        logic [2*RADIUS_W+1:0] sq;
        r    = (radius < RADIUS_W'(MAX_RADIUS)) ? radius : RADIUS_W'(MAX_RADIUS);
        side = {r, 1'b1};
        sq   = (2*RADIUS_W+2)'(side) * (2*RADIUS_W+2)'(side);
        return INDEX_W'(sq - 1'b1);
    endfunction

endpackage

/* sv/square_spiral_coordinate_sequencer.sv */
// Top level of the square spiral coordinate sequencer.
//
// Each input beat on the i_in_valid / o_in_ready channel advances the spiral by
// one cell, or starts again at the centre when i_restart is set. Each input beat
// yields exactly one output beat on o_out_valid / i_out_ready carrying the cell
// offsets, its order index and a flag on the final cell of the square.
// The beat after the flagged cell returns to the centre.
// The radius register is written through i_cfg_we and i_cfg_wdata; it is
// turned into the final order index at the write, so a change applies at once.
// The output beat follows in the cycle after its input beat. One beat is taken
// every cycle while the receiver keeps up: the next cell comes from the current
// one by one increment and a leg compare, and the result sits in an output
// register, so a new input beat is taken while the held result is taken in the same cycle.
// When the receiver stalls, the output register holds and the input side
// stops taking beats until the result is taken.
// Reset (synchronous, active low) empties the output register, returns the
// walk to the centre and sets the radius to two.
module square_spiral_coordinate_sequencer
    import ssq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [RADIUS_W-1:0]       i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_restart,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_coord_x,
    output logic signed [COORD_W-1:0] o_coord_y,
    output logic [INDEX_W-1:0]        o_order_index,
    output logic                      o_last
);

    logic [INDEX_W-1:0]        r_final;
    t_leg                      r_leg, n_leg;
    logic signed [COORD_W-1:0] r_pos_x, n_pos_x;
    logic signed [COORD_W-1:0] r_pos_y, n_pos_y;
    logic [PROGRESS_W-1:0]     r_prog, n_prog;
    logic [STEP_W-1:0]         r_step, n_step;
    logic [INDEX_W-1:0]        r_count, n_count;
    logic                      n_last;
    logic                      r_out_valid;

    logic                      in_accept;
    logic [PROGRESS_W-1:0]     prog_inc;
    logic [STEP_W-1:0]         prog_ext;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign prog_inc = r_prog + 1'b1;
    assign prog_ext = STEP_W'(prog_inc);

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_prog  = r_prog;
        n_step  = r_step;
        n_leg   = r_leg;
        n_count = r_count + 1'b1;
        if (i_restart) begin
            n_pos_x = '0;
            n_pos_y = '0;
            n_prog  = '0;
            n_step  = STEP_W'(FIRST_STEP);
            n_leg   = LEG_DROP;
            n_count = '0;
        end else begin
            unique case (r_leg)
                LEG_DROP: begin
                    n_pos_y = r_pos_y + 1'b1;
                    n_leg   = LEG_RIGHT;
                    n_prog  = '0;
                end
                LEG_RIGHT: begin
                    n_pos_x = r_pos_x + 1'b1;
                    n_prog  = prog_inc;
                    if (prog_ext >= r_step - 1'b1) begin
                        n_leg  = LEG_UP;
                        n_prog = '0;
                    end
                end
                LEG_UP: begin
                    n_pos_y = r_pos_y - 1'b1;
                    n_prog  = prog_inc;
                    if (prog_ext >= r_step) begin
                        n_leg  = LEG_LEFT;
                        n_prog = '0;
                    end
                end
                LEG_LEFT: begin
                    n_pos_x = r_pos_x - 1'b1;
                    n_prog  = prog_inc;
                    if (prog_ext >= r_step) begin
                        n_leg  = LEG_DOWN;
                        n_prog = '0;
                    end
                end
                LEG_DOWN: begin
                    n_pos_y = r_pos_y + 1'b1;
                    n_prog  = prog_inc;
                    if (prog_ext >= r_step) begin
                        n_leg  = LEG_DROP;
                        n_prog = '0;
                        n_step = r_step + STEP_W'(STEP_GROWTH);
                    end
                end
                default: begin
                    n_pos_x = '0;
                    n_pos_y = '0;
                    n_prog  = '0;
                    n_step  = STEP_W'(FIRST_STEP);
                    n_leg   = LEG_DROP;
                    n_count = '0;
                end
            endcase
        end
        n_last = (n_count >= r_final);
        if (n_last) begin
            n_leg = LEG_CENTRE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final     <= final_index(RADIUS_W'(RESET_RADIUS));
            r_leg       <= LEG_CENTRE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_prog      <= '0;
            r_step      <= STEP_W'(FIRST_STEP);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_final <= final_index(i_cfg_wdata);
            end
            if (in_accept) begin
                r_leg         <= n_leg;
                r_pos_x       <= n_pos_x;
                r_pos_y       <= n_pos_y;
                r_prog        <= n_prog;
                r_step        <= n_step;
                r_count       <= n_count;
                r_out_valid   <= 1'b1;
                o_coord_x     <= n_pos_x;
                o_coord_y     <= n_pos_y;
                o_order_index <= n_count;
                o_last        <= n_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_centre_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_order_index == '0 |-> o_coord_x == '0 && o_coord_y == '0)
        else $error("order index zero is not the centre cell");

    a_restart_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_restart |=> o_out_valid && o_order_index == '0)
        else $error("restart did not yield order index zero");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_last |=> r_leg == LEG_CENTRE && o_last)
        else $error("final cell did not return the walk to the centre");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_restart && r_leg != LEG_CENTRE
        |=> o_order_index == $past(r_count) + 1'b1)
        else $error("order index did not advance by one");

endmodule

/* test/square_spiral_coordinate_sequencer_test.sv */
// Testbench that checks the spiral sequencer beat by beat against a cycle-free predictor.
`timescale 1ns / 100ps

module square_spiral_coordinate_sequencer_test;
    import ssq_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_BEATS   = 1650;
    localparam int LONG_HOLD      = 300;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [INDEX_W-1:0]        index;
        logic                      last;
    } t_cell;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [RADIUS_W-1:0]       i_cfg_wdata = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      i_restart   = 1'b0;
    logic                      i_out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [COORD_W-1:0] o_coord_x;
    logic signed [COORD_W-1:0] o_coord_y;
    logic [INDEX_W-1:0]        o_order_index;
    logic                      o_last;

    logic [RADIUS_W-1:0]       radius_reg    = RADIUS_W'(RESET_RADIUS);
    logic signed [COORD_W-1:0] walk_x        = '0;
    logic signed [COORD_W-1:0] walk_y        = '0;
    t_leg                      walk_leg      = LEG_CENTRE;
    logic [PROGRESS_W-1:0]     walk_progress = '0;
    logic [STEP_W-1:0]         walk_step     = STEP_W'(FIRST_STEP);
    logic [INDEX_W-1:0]        walk_index    = '0;
    t_cell                     pending_cells[$];

    bit steady_flow  = 1'b0;
    bit hold_request = 1'b0;
    int failures     = 0;
    int beats_sent   = 0;
    int restarts     = 0;
    int cells_seen   = 0;
    int lasts_seen   = 0;
    int radius_writes = 0;
    int radius_min   = RESET_RADIUS;
    int radius_max   = RESET_RADIUS;
    int held_cycles  = 0;

    square_spiral_coordinate_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_coord_x     (o_coord_x),
        .o_coord_y     (o_coord_y),
        .o_order_index (o_order_index),
        .o_last        (o_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(8, 40);
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    task automatic predict_cell(input logic restart_bit);
        int    r;
        int    final_cell;
        t_cell entry;
        r = (radius_reg < MAX_RADIUS) ? radius_reg : MAX_RADIUS;
        final_cell = (2 * r + 1) * (2 * r + 1) - 1;
        if (restart_bit || walk_leg == LEG_CENTRE) begin
            walk_x        = '0;
            walk_y        = '0;
            walk_index    = '0;
            walk_step     = STEP_W'(FIRST_STEP);
            walk_progress = '0;
            walk_leg      = LEG_DROP;
        end else begin
            case (walk_leg)
                LEG_DROP: begin
                    walk_y++;
                    walk_leg      = LEG_RIGHT;
                    walk_progress = '0;
                end
                LEG_RIGHT: begin
                    walk_x++;
                    walk_progress++;
                    if (walk_progress >= walk_step - 1) begin
                        walk_leg      = LEG_UP;
                        walk_progress = '0;
                    end
                end
                LEG_UP: begin
                    walk_y--;
                    walk_progress++;
                    if (walk_progress >= walk_step) begin
                        walk_leg      = LEG_LEFT;
                        walk_progress = '0;
                    end
                end
                LEG_LEFT: begin
                    walk_x--;
                    walk_progress++;
                    if (walk_progress >= walk_step) begin
                        walk_leg      = LEG_DOWN;
                        walk_progress = '0;
                    end
                end
                default: begin
                    walk_y++;
                    walk_progress++;
                    if (walk_progress >= walk_step) begin
                        walk_leg      = LEG_DROP;
                        walk_progress = '0;
                        walk_step     = walk_step + STEP_W'(STEP_GROWTH);
                    end
                end
            endcase
            walk_index++;
        end
        entry.x     = walk_x;
        entry.y     = walk_y;
        entry.index = walk_index;
        entry.last  = (walk_index >= final_cell);
        if (entry.last) begin
            walk_leg = LEG_CENTRE;
        end
        pending_cells.push_back(entry);
        beats_sent++;
        if (restart_bit) begin
            restarts++;
        end
    endtask

    task automatic send_beat(input logic restart_bit);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_restart  <= 1'($urandom);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_restart  <= restart_bit;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_cell(restart_bit);
    endtask

    task automatic send_run(input int count, input int restart_odds);
        for (int n = 0; n < count; n++) begin
            send_beat(restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        radius_reg = value;
        radius_writes++;
        if (value < radius_min) begin
            radius_min = value;
        end
        if (value > radius_max) begin
            radius_max = value;
        end
    endtask

    // The reset radius of two must give a full 25-cell square and then wrap.
    task automatic test_reset_square();
        send_run(26, 0);
    endtask

    task automatic test_restart();
        send_run(3, 0);
        send_beat(1'b1);
        send_beat(1'b1);
        send_run(5, 0);
    endtask

    // Shrinking to radius zero mid-walk flags the next cell, then only the centre remains.
    task automatic test_shrink_to_zero();
        write_radius(RADIUS_W'(0));
        send_run(3, 0);
    endtask

    task automatic test_max_radius();
        write_radius(RADIUS_W'(MAX_RADIUS));
        send_run(4, 0);
        send_beat(1'b1);
    endtask

    task automatic test_receiver_hold();
        write_radius(RADIUS_W'(2));
        steady_flow  = 1'b0;
        hold_request = 1'b1;
        send_run(20, 8);
        drain();
    endtask

    task automatic test_random_walks();
        int done_beats;
        int sel;
        int len;
        int side;
        logic [RADIUS_W-1:0] r;
        done_beats = 0;
        while (done_beats < RANDOM_BEATS) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                r = RADIUS_W'($urandom_range(0, 4));
            end else if (sel < 9) begin
                r = RADIUS_W'($urandom_range(5, 12));
            end else begin
                r = RADIUS_W'($urandom_range(13, MAX_RADIUS));
            end
            if ($urandom_range(0, 3) != 0) begin
                write_radius(r);
            end
            steady_flow = ($urandom_range(0, 3) == 0);
            side = 2 * radius_reg + 1;
            if (radius_reg <= 5) begin
                len = $urandom_range(1, (side * side * 2 + 2 < 150) ? side * side * 2 + 2 : 150);
            end else begin
                len = $urandom_range(1, 60);
            end
            send_run(len, 40);
            done_beats += len;
        end
        steady_flow = 1'b0;
        drain();
    endtask

    initial begin : pace_output
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                for (int n = 1; n < LONG_HOLD; n++) begin
                    @(negedge i_clk);
                end
                held_cycles += LONG_HOLD;
                hold_request = 1'b0;
            end else if (steady_flow || $urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b1;
            end else begin
                gap = pick_gap() + 1;
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_cells
        t_cell want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            cells_seen++;
            if (o_last) begin
                lasts_seen++;
            end
            if (pending_cells.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("tb: unexpected beat x=%0d y=%0d index=%0d last=%0b",
                             o_coord_x, o_coord_y, o_order_index, o_last);
                end
            end else begin
                want = pending_cells.pop_front();
                if (o_coord_x !== want.x || o_coord_y !== want.y ||
                    o_order_index !== want.index || o_last !== want.last) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("tb: mismatch expected x=%0d y=%0d index=%0d last=%0b",
                                 want.x, want.y, want.index, want.last);
                        $display("tb:          got x=%0d y=%0d index=%0d last=%0b",
                                 o_coord_x, o_coord_y, o_order_index, o_last);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin : run_tests
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_square();
        test_restart();
        test_shrink_to_zero();
        test_max_radius();
        test_receiver_hold();
        test_random_walks();

        drain();
        failures += pending_cells.size();
        $display("tb: %0d beats sent with %0d restarts, %0d cells checked, %0d final cells seen",
                 beats_sent, restarts, cells_seen, lasts_seen);
        $display("tb: %0d radius writes from %0d to %0d, output held for %0d cycles",
                 radius_writes, radius_min, radius_max, held_cycles);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
